// ===== design/atu_pkg.sv =====
`default_nettype none
package atu_pkg;

  localparam int WORD_W          = 24;
  localparam int SAMPLE_W        = 20;
  localparam int SAMPLE_LSB      = 4;
  localparam int ANGLE_W         = 16;
  localparam int CORDIC_STAGES   = 16;
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int GUARD_BITS      = 8;
  localparam int ACC_FRAC        = 16;
  localparam int TABLE_LEN       = 24;
  localparam int N_ITER          = (CORDIC_STAGES > TABLE_LEN) ? TABLE_LEN : CORDIC_STAGES;

  localparam int XW    = 32;
  localparam int ACC_W = 26;

  localparam int RND_SH   = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam int ANG_FULL = 90 << ANGLE_FRAC_BITS;
  localparam int ANG_HI   = (ANG_FULL > 32767) ? 32767 : ANG_FULL;
  localparam int ANG_LO   = (ANG_FULL > 32768) ? -32768 : -ANG_FULL;

  localparam logic signed [ACC_W-1:0] ANG_FULL_A = ACC_W'(ANG_FULL);
  localparam logic signed [ACC_W-1:0] ANG_HI_A   = ACC_W'(ANG_HI);
  localparam logic signed [ACC_W-1:0] ANG_LO_A   = ACC_W'(ANG_LO);
  localparam logic signed [ACC_W-1:0] RND_HALF_A = ACC_W'(1) <<< (RND_SH - 1);

  localparam logic signed [ANGLE_W-1:0] ANG_HI_S = ANGLE_W'(ANG_HI);
  localparam logic signed [ANGLE_W-1:0] ANG_LO_S = ANGLE_W'(ANG_LO);

  // atan(2^-i) in degrees, 16 fractional bits
  localparam logic signed [ACC_W-1:0] ATAN_TAB [TABLE_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
  } atu_sample_t;

endpackage
`default_nettype wire

// ===== design/atu_cordic_lane.sv =====
`default_nettype none
module atu_cordic_lane
  import atu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic [N_ITER:0]           ld,
  input  wire logic signed [SAMPLE_W-1:0] num,
  input  wire logic signed [SAMPLE_W-1:0] den,
  output logic signed [ACC_W-1:0]         acc_o
);

  logic signed [XW-1:0]    x_r   [N_ITER+1];
  logic signed [XW-1:0]    y_r   [N_ITER+1];
  logic signed [ACC_W-1:0] acc_r [N_ITER+1];

  logic signed [XW-1:0] num_e;
  logic signed [XW-1:0] den_e;
  logic signed [XW-1:0] x_nxt;
  logic signed [XW-1:0] y_nxt;

  assign num_e = {{(XW-SAMPLE_W){num[SAMPLE_W-1]}}, num};
  assign den_e = {{(XW-SAMPLE_W){den[SAMPLE_W-1]}}, den};

  // fold into the right half plane
  always_comb begin
    if (den[SAMPLE_W-1]) begin
      x_nxt = (-den_e) <<< GUARD_BITS;
      y_nxt = (-num_e) <<< GUARD_BITS;
    end else begin
      x_nxt = den_e <<< GUARD_BITS;
      y_nxt = num_e <<< GUARD_BITS;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      x_r[0]   <= x_nxt;
      y_r[0]   <= y_nxt;
      acc_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= N_ITER; k++) begin : g_iter
    logic signed [XW-1:0] dx;
    logic signed [XW-1:0] dy;
    assign dx = y_r[k-1] >>> (k - 1);
    assign dy = x_r[k-1] >>> (k - 1);
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        if (!y_r[k-1][XW-1]) begin
          x_r[k]   <= x_r[k-1] + dx;
          y_r[k]   <= y_r[k-1] - dy;
          acc_r[k] <= acc_r[k-1] + ATAN_TAB[k-1];
        end else begin
          x_r[k]   <= x_r[k-1] - dx;
          y_r[k]   <= y_r[k-1] + dy;
          acc_r[k] <= acc_r[k-1] - ATAN_TAB[k-1];
        end
      end
    end
  end

  assign acc_o = acc_r[N_ITER];

endmodule
`default_nettype wire

// ===== design/atu_merge.sv =====
`default_nettype none
module atu_merge
  import atu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      ld,
  input  wire atu_sample_t               smp,
  input  wire logic signed [ACC_W-1:0]   acc_yz,
  input  wire logic signed [ACC_W-1:0]   acc_zx,
  output logic signed [SAMPLE_W-1:0]     accel_x,
  output logic signed [SAMPLE_W-1:0]     accel_y,
  output logic signed [SAMPLE_W-1:0]     accel_z,
  output logic signed [ANGLE_W-1:0]      tilt_yz,
  output logic signed [ANGLE_W-1:0]      tilt_zx,
  output logic                           z_is_zero
);

  function automatic logic signed [ANGLE_W-1:0] angle(
    input logic signed [ACC_W-1:0]    acc,
    input logic                       zz,
    input logic signed [SAMPLE_W-1:0] num
  );
    logic signed [ACC_W-1:0] r;
    if (zz) begin
      if (num > 0) begin
        r = ANG_FULL_A;
      end else if (num < 0) begin
        r = -ANG_FULL_A;
      end else begin
        r = '0;
      end
    end else begin
      r = (acc + RND_HALF_A) >>> RND_SH;
    end
    if (r > ANG_HI_A) begin
      r = ANG_HI_A;
    end
    if (r < ANG_LO_A) begin
      r = ANG_LO_A;
    end
    return r[ANGLE_W-1:0];
  endfunction

  logic zz;
  assign zz = (smp.az == '0);

  always_ff @(posedge clk) begin
    if (ld) begin
      accel_x   <= smp.ax;
      accel_y   <= smp.ay;
      accel_z   <= smp.az;
      tilt_yz   <= angle(acc_yz, zz, smp.ay);
      tilt_zx   <= angle(acc_zx, zz, smp.ax);
      z_is_zero <= zz;
    end
  end

endmodule
`default_nettype wire

// ===== design/accel_tilt_angle_unit.sv =====
`default_nettype none
// channel | direction | handshake            | payload
// in_     | input     | in_valid / in_ready   | x_word, y_word, z_word (24 bit raw)
// out_    | output    | out_valid / out_ready | accel_x/y/z, tilt_yz, tilt_zx, z_is_zero
//
// one transaction per cycle while out_ready does not stall the pipe; stages: fold, 16 cordic stages, output
// two cordic lanes, one per angle, share the stage valid chain and a merge register
// each stage advances when the stage after it is empty or moving, so bubbles collapse
// and inputs are taken while a result waits until the whole pipe is full
// synchronous active-low reset clears the valid bits only
module accel_tilt_angle_unit
  import atu_pkg::*;
(
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [WORD_W-1:0]         in_x_word,
  input  wire logic [WORD_W-1:0]         in_y_word,
  input  wire logic [WORD_W-1:0]         in_z_word,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic signed [SAMPLE_W-1:0]     out_accel_x,
  output logic signed [SAMPLE_W-1:0]     out_accel_y,
  output logic signed [SAMPLE_W-1:0]     out_accel_z,
  output logic signed [ANGLE_W-1:0]      out_tilt_yz,
  output logic signed [ANGLE_W-1:0]      out_tilt_zx,
  output logic                           out_z_is_zero
);

  logic [N_ITER:0]   valid_r;
  logic              out_valid_r;
  logic [N_ITER+1:0] space;
  atu_sample_t       smp_in;
  atu_sample_t       smp_r [N_ITER+1];
  logic signed [ACC_W-1:0] acc_yz;
  logic signed [ACC_W-1:0] acc_zx;

  assign smp_in.ax = in_x_word[SAMPLE_LSB +: SAMPLE_W];
  assign smp_in.ay = in_y_word[SAMPLE_LSB +: SAMPLE_W];
  assign smp_in.az = in_z_word[SAMPLE_LSB +: SAMPLE_W];

  assign space[N_ITER+1] = !out_valid_r || out_ready;
  for (genvar k = 0; k <= N_ITER; k++) begin : g_space
    assign space[k] = !valid_r[k] || space[k+1];
  end

  assign in_ready  = space[0];
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else if (space[0]) begin
      valid_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (space[0]) begin
      smp_r[0] <= smp_in;
    end
  end

  for (genvar k = 1; k <= N_ITER; k++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (space[k]) begin
        valid_r[k] <= valid_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (space[k]) begin
        smp_r[k] <= smp_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (space[N_ITER+1]) begin
      out_valid_r <= valid_r[N_ITER];
    end
  end

  atu_cordic_lane u_lane_yz (
    .clk   (clk),
    .ld    (space[N_ITER:0]),
    .num   (smp_in.ay),
    .den   (smp_in.az),
    .acc_o (acc_yz)
  );

  atu_cordic_lane u_lane_zx (
    .clk   (clk),
    .ld    (space[N_ITER:0]),
    .num   (smp_in.ax),
    .den   (smp_in.az),
    .acc_o (acc_zx)
  );

  atu_merge u_merge (
    .clk       (clk),
    .ld        (space[N_ITER+1]),
    .smp       (smp_r[N_ITER]),
    .acc_yz    (acc_yz),
    .acc_zx    (acc_zx),
    .accel_x   (out_accel_x),
    .accel_y   (out_accel_y),
    .accel_z   (out_accel_z),
    .tilt_yz   (out_tilt_yz),
    .tilt_zx   (out_tilt_zx),
    .z_is_zero (out_z_is_zero)
  );

`ifndef SYNTH
  a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid_r && !out_ready && (&valid_r)))
    else $error("input stalled with room in the pipe");

  a_zero_flag : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_z_is_zero == (out_accel_z == '0)))
    else $error("z flag does not match z sample");

  a_zero_angle : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_z_is_zero) |->
      ((out_tilt_yz == '0 || out_tilt_yz == ANG_HI_S || out_tilt_yz == ANG_LO_S) &&
       (out_tilt_zx == '0 || out_tilt_zx == ANG_HI_S || out_tilt_zx == ANG_LO_S)))
    else $error("clamped angle not at a limit");

  a_angle_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_tilt_yz <= ANG_HI_S && out_tilt_yz >= ANG_LO_S &&
                     out_tilt_zx <= ANG_HI_S && out_tilt_zx >= ANG_LO_S))
    else $error("angle outside limits");
`endif

endmodule
`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
module tb_top;
  import atu_pkg::*;

  localparam int N_RANDOM   = 550;
  localparam int LONG_HOLD  = 300;
  localparam int HOLD_AFTER = 200;
  localparam int DRAIN_A    = 25;
  localparam int DRAIN_B    = 400;
  localparam int TAIL       = 2 * (N_ITER + 2) + 8;

  typedef struct packed {
    logic [WORD_W-1:0] xw;
    logic [WORD_W-1:0] yw;
    logic [WORD_W-1:0] zw;
  } word_triple_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] ax;
    logic signed [SAMPLE_W-1:0] ay;
    logic signed [SAMPLE_W-1:0] az;
    logic signed [ANGLE_W-1:0]  tyz;
    logic signed [ANGLE_W-1:0]  tzx;
    logic                       zz;
  } tilt_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [WORD_W-1:0] in_x_word = '0;
  logic [WORD_W-1:0] in_y_word = '0;
  logic [WORD_W-1:0] in_z_word = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SAMPLE_W-1:0] out_accel_x;
  logic signed [SAMPLE_W-1:0] out_accel_y;
  logic signed [SAMPLE_W-1:0] out_accel_z;
  logic signed [ANGLE_W-1:0] out_tilt_yz;
  logic signed [ANGLE_W-1:0] out_tilt_zx;
  logic out_z_is_zero;

  word_triple_t sample_words_q[$];
  tilt_result_t tilt_due_q[$];

  logic in_acc = 1'b0;
  int fail_cnt = 0;
  int checked_cnt = 0;
  int zero_z_cnt = 0;
  int sent_cnt = 0;
  int burst_left = 8;
  int gap_left = 0;
  int hold_left = 0;
  bit long_done = 1'b0;
  int rx_mode = 0;
  int rx_phase = 0;

  accel_tilt_angle_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_x_word    (in_x_word),
    .in_y_word    (in_y_word),
    .in_z_word    (in_z_word),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_accel_x  (out_accel_x),
    .out_accel_y  (out_accel_y),
    .out_accel_z  (out_accel_z),
    .out_tilt_yz  (out_tilt_yz),
    .out_tilt_zx  (out_tilt_zx),
    .out_z_is_zero(out_z_is_zero)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [ANGLE_W-1:0] tilt_degrees(
    logic signed [SAMPLE_W-1:0] num, logic signed [SAMPLE_W-1:0] den);
    longint x, y, acc, r, dx, dy, full;
    int sh;
    full = longint'(90) <<< ANGLE_FRAC_BITS;
    acc = 0;
    if (den == 0) begin
      if (num > 0) r = full;
      else if (num < 0) r = -full;
      else r = 0;
    end else begin
      x = longint'(den) * (longint'(1) <<< GUARD_BITS);
      y = longint'(num) * (longint'(1) <<< GUARD_BITS);
      if (den < 0) begin
        x = -x;
        y = -y;
      end
      for (int i = 0; i < N_ITER; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx;
          y -= dy;
          acc += longint'(ATAN_TAB[i]);
        end else begin
          x -= dx;
          y += dy;
          acc -= longint'(ATAN_TAB[i]);
        end
      end
      sh = ACC_FRAC - ANGLE_FRAC_BITS;
      if (sh > 0) r = (acc + (longint'(1) <<< (sh - 1))) >>> sh;
      else r = acc <<< (-sh);
    end
    if (r > full) r = full;
    if (r < -full) r = -full;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return ANGLE_W'(r);
  endfunction

  function automatic tilt_result_t tilt_predict(word_triple_t w);
    tilt_result_t r;
    r.ax = w.xw[WORD_W-1:SAMPLE_LSB];
    r.ay = w.yw[WORD_W-1:SAMPLE_LSB];
    r.az = w.zw[WORD_W-1:SAMPLE_LSB];
    r.tyz = tilt_degrees(r.ay, r.az);
    r.tzx = tilt_degrees(r.ax, r.az);
    r.zz = (r.az == 0);
    return r;
  endfunction

  function automatic word_triple_t raw_triple(int x, int y, int z);
    word_triple_t w;
    w.xw = {SAMPLE_W'(x), 4'($urandom)};
    w.yw = {SAMPLE_W'(y), 4'($urandom)};
    w.zw = {SAMPLE_W'(z), 4'($urandom)};
    return w;
  endfunction

  // sender: bursts of transactions with random gaps, two drain points
  always @(negedge clk) begin
    word_triple_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_acc) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (sample_words_q.size() == 0 ||
                   ((sent_cnt == DRAIN_A || sent_cnt == DRAIN_B) && tilt_due_q.size() != 0)) begin
        in_valid <= 1'b0;
      end else begin
        w = sample_words_q.pop_front();
        in_valid  <= 1'b1;
        in_x_word <= w.xw;
        in_y_word <= w.yw;
        in_z_word <= w.zw;
        sent_cnt++;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end
    end
  end

  // receiver: stall pattern redrawn each time rx_phase wraps, one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!long_done && checked_cnt >= HOLD_AFTER) begin
      long_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      out_ready <= 1'b0;
    end else begin
      if (rx_phase == 0) rx_mode = $urandom_range(0, 3);
      case (rx_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= 1'($urandom);
        2: out_ready <= ($urandom_range(0, 7) != 0);
        default: out_ready <= (rx_phase % 3 == 0);
      endcase
      rx_phase = (rx_phase + 1) % 48;
    end
  end

  // monitor: check the oldest expected transaction, then record new inputs
  always @(posedge clk) begin
    tilt_result_t e;
    word_triple_t w;
    in_acc <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (tilt_due_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_cnt++;
        end else begin
          e = tilt_due_q.pop_front();
          checked_cnt++;
          if (e.zz) zero_z_cnt++;
          if (out_accel_x !== e.ax) begin
            $error("accel_x: expected %0d, got %0d", e.ax, out_accel_x);
            fail_cnt++;
          end
          if (out_accel_y !== e.ay) begin
            $error("accel_y: expected %0d, got %0d", e.ay, out_accel_y);
            fail_cnt++;
          end
          if (out_accel_z !== e.az) begin
            $error("accel_z: expected %0d, got %0d", e.az, out_accel_z);
            fail_cnt++;
          end
          if (out_tilt_yz !== e.tyz) begin
            $error("tilt_yz: expected %0d, got %0d", e.tyz, out_tilt_yz);
            fail_cnt++;
          end
          if (out_tilt_zx !== e.tzx) begin
            $error("tilt_zx: expected %0d, got %0d", e.tzx, out_tilt_zx);
            fail_cnt++;
          end
          if (out_z_is_zero !== e.zz) begin
            $error("z_is_zero: expected %0d, got %0d", e.zz, out_z_is_zero);
            fail_cnt++;
          end
        end
      end
      if (in_valid && in_ready) begin
        w.xw = in_x_word;
        w.yw = in_y_word;
        w.zw = in_z_word;
        tilt_due_q.push_back(tilt_predict(w));
      end
    end
  end

  initial begin
    int kind, x, y, z;
    // zero z with every numerator sign
    sample_words_q.push_back(raw_triple(0, 0, 0));
    sample_words_q.push_back(raw_triple(-5, 7, 0));
    sample_words_q.push_back(raw_triple(3, -9, 0));
    sample_words_q.push_back(raw_triple(-524288, 524287, 0));
    // extremes of the samples
    sample_words_q.push_back(raw_triple(524287, -524288, 524287));
    sample_words_q.push_back(raw_triple(-524288, 524287, -524288));
    sample_words_q.push_back(raw_triple(524287, 524287, -524288));
    sample_words_q.push_back(raw_triple(-524288, -524288, 524287));
    // tiny z, angle pushed to the clamp
    sample_words_q.push_back(raw_triple(524287, 1, -1));
    sample_words_q.push_back(raw_triple(-524288, 524287, 1));
    sample_words_q.push_back(raw_triple(1, -524288, 1));
    sample_words_q.push_back(raw_triple(-1, -524288, -1));
    // numerator zero, z nonzero
    sample_words_q.push_back(raw_triple(0, 0, 5));
    sample_words_q.push_back(raw_triple(0, 0, -7));
    sample_words_q.push_back(raw_triple(0, 0, -524288));
    // 45 degree ratios
    sample_words_q.push_back(raw_triple(1000, -1000, 1000));
    sample_words_q.push_back(raw_triple(-2000, 2000, -2000));
    // ignored low nibble
    sample_words_q.push_back('{xw: 24'hFFFFFF, yw: 24'h00000F, zw: 24'hFFFFF0});
    sample_words_q.push_back('{xw: 24'h00000F, yw: 24'hFFFFFF, zw: 24'h00001F});
    sample_words_q.push_back(raw_triple(16384, 100, 262144));
    for (int i = 0; i < N_RANDOM; i++) begin
      kind = $urandom_range(0, 9);
      x = $urandom_range(0, 20'hFFFFF);
      y = $urandom_range(0, 20'hFFFFF);
      z = $urandom_range(0, 20'hFFFFF);
      case (kind)
        0: z = 0;
        1: z = int'($urandom_range(0, 6)) - 3;
        2: begin
          x = int'($urandom_range(0, 6)) - 3;
          y = int'($urandom_range(0, 6)) - 3;
        end
        3: y = int'(SAMPLE_W'(z)) + int'($urandom_range(0, 64)) - 32;
        default: ;
      endcase
      if (kind >= 4) begin
        sample_words_q.push_back('{xw: 24'($urandom), yw: 24'($urandom), zw: 24'($urandom)});
      end else begin
        sample_words_q.push_back(raw_triple(x, y, z));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    while (sample_words_q.size() != 0 || in_valid || tilt_due_q.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);
    $display("%0d sample triples sent, %0d results checked, %0d of them with zero z",
             sent_cnt, checked_cnt, zero_z_cnt);
    $display("long output hold-off %0s, sender drained at transactions %0d and %0d",
             long_done ? "done" : "not reached", DRAIN_A, DRAIN_B);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/atu_pkg.sv
design/atu_cordic_lane.sv
design/atu_merge.sv
design/accel_tilt_angle_unit.sv
bench/tb_top.sv
